// ----- hw/rtl/first_seen_port_index_assigner_core_assert.svh -----
// Assertion macros shared by the checkers of the port index assigner.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef FIRST_SEEN_PORT_INDEX_ASSIGNER_CORE_ASSERT_SVH
`define FIRST_SEEN_PORT_INDEX_ASSIGNER_CORE_ASSERT_SVH

// Same-cycle implication; the consequent may also open with a constant delay.
`define FSPIA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("port index assigner: implication check failed");

// Next-cycle implication.
`define FSPIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port index assigner: next-cycle check failed");

`endif

// ----- hw/rtl/fspia_pkg.sv -----
// Package of the first-seen port index assigner: field widths, command codes
// and the command and status structs between controller and datapath.
package fspia_pkg;

  localparam int KeyBitsDef = 16;
  localparam int FuncWidth  = 2;
  localparam int PortWidth  = 16;
  localparam int PosWidth   = 17;
  localparam int IdxWidth   = 17;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_INDEX = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the transaction and launch the table reads
    logic exec;     // evaluate, update the tables and load the result
    logic sweep;    // zero one forward table entry
  } fspia_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;    // result register empty or being taken
    logic is_clear;    // latched command is a clear
    logic sweep_last;  // sweep address is at the last entry
  } fspia_status_t;

endpackage

// ----- hw/rtl/fspia_ctrl.sv -----
// Controller of the port index assigner: sequences table sweeps, transaction
// capture and execution. Depends on fspia_pkg.
module fspia_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  fspia_pkg::fspia_status_t status_i,
  output fspia_pkg::fspia_cmd_t    cmd_o
);
  import fspia_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = status_i.out_free;
        cmd_o.capture = in_valid_i & status_i.out_free;
        if (cmd_o.capture) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        // A clear hands its result out first, then walks the forward table.
        state_d = status_i.is_clear ? ST_SWEEP : ST_IDLE;
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

endmodule

// ----- hw/rtl/fspia_dp.sv -----
// Datapath of the port index assigner: forward and reverse tables, entry
// counter, sweep address and result register. Depends on fspia_pkg.
module fspia_dp #(
  parameter int KeyBits = fspia_pkg::KeyBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fspia_pkg::fspia_cmd_t             cmd_i,
  output fspia_pkg::fspia_status_t          status_o,
  input  logic [fspia_pkg::FuncWidth-1:0]   func_i,
  input  logic [fspia_pkg::PortWidth-1:0]   port_i,
  input  logic [fspia_pkg::PosWidth-1:0]    position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fspia_pkg::IdxWidth-1:0]    assigned_index_o,
  output logic [fspia_pkg::PortWidth-1:0]   port_out_o,
  output logic [fspia_pkg::IdxWidth-1:0]    entry_count_o,
  output logic                              newly_added_o,
  output logic                              in_range_o
);
  import fspia_pkg::*;

  localparam int Depth = 1 << KeyBits;
  localparam int CntW  = KeyBits + 1;

  // Forward table holds dense index, zero meaning unseen.
  logic [CntW-1:0]    fwd_mem [Depth];
  logic [KeyBits-1:0] rev_mem [Depth];

  logic [CntW-1:0]    fwd_rdata_q;
  logic [KeyBits-1:0] rev_rdata_q;
  logic [KeyBits-1:0] key_q;
  func_e              func_q;
  logic [PosWidth-1:0] pos_q;

  logic [CntW-1:0]    count_q, count_d;
  logic [KeyBits-1:0] sweep_addr_q, sweep_addr_d;

  logic               out_valid_q, out_valid_d;
  logic [IdxWidth-1:0] assigned_q;
  logic [PortWidth-1:0] port_out_q;
  logic [IdxWidth-1:0] count_out_q;
  logic               added_q;
  logic               in_range_q;

  logic [KeyBits-1:0] rev_raddr;
  logic [CntW-1:0]    count_inc;
  logic               is_index;
  logic               is_read;
  logic               is_clear;
  logic               add;
  logic               pos_ok;
  logic [CntW-1:0]    assigned;
  logic               fwd_we;
  logic [KeyBits-1:0] fwd_waddr;
  logic [CntW-1:0]    fwd_wdata;
  logic               rev_we;

  assign rev_raddr = position_i[KeyBits-1:0] - KeyBits'(1);
  assign count_inc = count_q + CntW'(1);
  assign is_index  = (func_q == FUNC_INDEX);
  assign is_read   = (func_q == FUNC_READ);
  assign is_clear  = (func_q == FUNC_CLEAR);
  // The top count bit is set only when every key already has an index.
  assign add       = is_index && (fwd_rdata_q == '0) && !count_q[CntW-1];
  assign pos_ok    = is_read && (pos_q != '0) && (pos_q <= PosWidth'(count_q));
  assign assigned  = !is_index ? '0 : (add ? count_inc : fwd_rdata_q);

  assign fwd_we    = cmd_i.sweep | (cmd_i.exec & add);
  assign fwd_waddr = cmd_i.sweep ? sweep_addr_q : key_q;
  assign fwd_wdata = cmd_i.sweep ? '0 : count_inc;
  assign rev_we    = cmd_i.exec & add;

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    if (cmd_i.capture) begin
      fwd_rdata_q <= fwd_mem[port_i[KeyBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rev_we) begin
      rev_mem[count_q[KeyBits-1:0]] <= key_q;
    end
    if (cmd_i.capture) begin
      rev_rdata_q <= rev_mem[rev_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q  <= port_i[KeyBits-1:0];
      func_q <= func_e'(func_i);
      pos_q  <= position_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.exec && is_clear) begin
      count_d = '0;
    end else if (cmd_i.exec && add) begin
      count_d = count_inc;
    end
  end

  always_comb begin
    sweep_addr_d = sweep_addr_q;
    if (cmd_i.exec && is_clear) begin
      sweep_addr_d = '0;
    end else if (cmd_i.sweep) begin
      sweep_addr_d = sweep_addr_q + KeyBits'(1);
    end
  end

  assign out_valid_d = cmd_i.exec | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      sweep_addr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      sweep_addr_q <= sweep_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      assigned_q  <= IdxWidth'(assigned);
      port_out_q  <= pos_ok ? PortWidth'(rev_rdata_q) : '0;
      count_out_q <= IdxWidth'(count_d);
      added_q     <= add;
      in_range_q  <= pos_ok;
    end
  end

  assign status_o.out_free   = ~out_valid_q | out_ready_i;
  assign status_o.is_clear   = is_clear;
  assign status_o.sweep_last = (sweep_addr_q == '1);

  assign out_valid_o      = out_valid_q;
  assign assigned_index_o = assigned_q;
  assign port_out_o       = port_out_q;
  assign entry_count_o    = count_out_q;
  assign newly_added_o    = added_q;
  assign in_range_o       = in_range_q;

endmodule

// ----- hw/rtl/first_seen_port_index_assigner_core.sv -----
// A transaction is latched with its registered table reads, then evaluated into the result register;
// no new transaction is taken until the last has been executed and the result register is free.
// A clear returns its result, then zeroes the forward table one entry a cycle,
// all 2**KeyBits entries (65536 by default), with the input held not ready.
// After reset the same forward table sweep runs before the first transaction.
// Reset is asynchronous, active low, and clears the count and all control state.
module first_seen_port_index_assigner_core #(
  parameter int KeyBits = fspia_pkg::KeyBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fspia_pkg::FuncWidth-1:0] func_i,
  input  logic [fspia_pkg::PortWidth-1:0] port_i,
  input  logic [fspia_pkg::PosWidth-1:0]  position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fspia_pkg::IdxWidth-1:0]  assigned_index_o,
  output logic [fspia_pkg::PortWidth-1:0] port_out_o,
  output logic [fspia_pkg::IdxWidth-1:0]  entry_count_o,
  output logic                            newly_added_o,
  output logic                            in_range_o
);
  import fspia_pkg::*;

  fspia_cmd_t    cmd;
  fspia_status_t status;

  fspia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fspia_dp #(
    .KeyBits (KeyBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .func_i           (func_i),
    .port_i           (port_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .assigned_index_o (assigned_index_o),
    .port_out_o       (port_out_o),
    .entry_count_o    (entry_count_o),
    .newly_added_o    (newly_added_o),
    .in_range_o       (in_range_o)
  );

endmodule

// ----- hw/rtl/fspia_checker.sv -----
// Port-level checker for the port index assigner, bound to the top level.
// Depends on fspia_pkg and the assertion macro header.
`include "first_seen_port_index_assigner_core_assert.svh"

module fspia_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [fspia_pkg::IdxWidth-1:0]  assigned_index_o,
  input logic [fspia_pkg::PortWidth-1:0] port_out_o,
  input logic [fspia_pkg::IdxWidth-1:0]  entry_count_o,
  input logic                            newly_added_o,
  input logic                            in_range_o
);
  import fspia_pkg::*;

  logic                               in_acc;
  logic                               new_ok;
  logic                               out_wait;
  logic [2*IdxWidth+PortWidth+1:0]    result_bus;

  assign in_acc     = in_valid_i & in_ready_o;
  // A first sighting takes the newest index, and it is never a read result.
  assign new_ok     = (assigned_index_o == entry_count_o) && !in_range_o;
  assign out_wait   = out_valid_o & ~out_ready_i;
  assign result_bus = {assigned_index_o, port_out_o, entry_count_o, newly_added_o, in_range_o};

  // The result register must be free before a new transaction enters.
  `FSPIA_ASSERT_IMPLY(a_ready_needs_room, clk_i, rst_ni, in_ready_o, (!out_valid_o || out_ready_i))
  // An accepted transaction produces its result once it has been captured and executed.
  `FSPIA_ASSERT_IMPLY(a_result_follows, clk_i, rst_ni, in_acc, ##2 out_valid_o)
  // Only one transaction is in flight.
  `FSPIA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_acc, !in_ready_o)
  `FSPIA_ASSERT_IMPLY(a_new_is_newest, clk_i, rst_ni, (out_valid_o && newly_added_o), new_ok)
  `FSPIA_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_wait, (out_valid_o && $stable(result_bus)))

endmodule

bind first_seen_port_index_assigner_core fspia_checker u_fspia_checker (.*);

// ----- tb/first_seen_port_index_assigner_core_tb.sv -----
// Self-checking testbench for first_seen_port_index_assigner_core: directed and
// random index, read, clear and no-op transactions against a built-in predictor.
// Depends on fspia_pkg for the field widths and the command codes.
module first_seen_port_index_assigner_core_tb;
  import fspia_pkg::*;

  localparam int KeyBits           = KeyBitsDef;
  localparam int KeyDepth          = 1 << KeyBits;
  localparam int RandomClearBudget = 4;
  localparam int ItemBudget        = 1550;
  localparam int MaxCycles         = (RandomClearBudget + 4) * KeyDepth * 3 + ItemBudget * 200;
  localparam int TailCycles        = 16;
  localparam int MaxReported       = 10;
  localparam int PoolSize          = 48;

  typedef struct packed {
    logic [IdxWidth-1:0]  assigned_index;
    logic [PortWidth-1:0] port_out;
    logic [IdxWidth-1:0]  entry_count;
    logic                 newly_added;
    logic                 in_range;
  } port_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FuncWidth-1:0] func_i;
  logic [PortWidth-1:0] port_i;
  logic [PosWidth-1:0]  position_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [IdxWidth-1:0]  assigned_index_o;
  logic [PortWidth-1:0] port_out_o;
  logic [IdxWidth-1:0]  entry_count_o;
  logic                 newly_added_o;
  logic                 in_range_o;

  first_seen_port_index_assigner_core #(
    .KeyBits(KeyBits)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .port_i          (port_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .assigned_index_o(assigned_index_o),
    .port_out_o      (port_out_o),
    .entry_count_o   (entry_count_o),
    .newly_added_o   (newly_added_o),
    .in_range_o      (in_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: forward map from key to dense index, reverse map from
  // index minus one to key, and the count of distinct keys.
  logic [IdxWidth-1:0]  index_of_key [int];
  logic [PortWidth-1:0] key_at_slot  [int];
  int                   distinct_count;

  port_result_t         expected_results_q [$];
  port_result_t         observed_result;
  port_result_t         oldest_result;
  logic [PortWidth-1:0] port_pool [PoolSize];
  int                   mismatch_count;
  int                   cycle_count;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   clears_left;

  function automatic port_result_t predict_port_result(input func_e func,
                                                       input logic [PortWidth-1:0] port,
                                                       input logic [PosWidth-1:0] position);
    port_result_t res;
    int           key;
    res = '0;
    key = int'(port) % KeyDepth;
    case (func)
      FUNC_INDEX: begin
        if (!index_of_key.exists(key) && distinct_count < KeyDepth) begin
          distinct_count++;
          index_of_key[key] = IdxWidth'(distinct_count);
          key_at_slot[distinct_count - 1] = PortWidth'(key);
          res.newly_added = 1'b1;
        end
        if (index_of_key.exists(key)) begin
          res.assigned_index = index_of_key[key];
        end
      end
      FUNC_READ: begin
        if (position >= 1 && int'(position) <= distinct_count) begin
          res.in_range = 1'b1;
          res.port_out = key_at_slot[int'(position) - 1];
        end
      end
      FUNC_CLEAR: begin
        index_of_key.delete();
        distinct_count = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = IdxWidth'(distinct_count);
    return res;
  endfunction

  task automatic report_mismatch(input port_result_t want, input port_result_t got,
                                 input bit orphan);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      if (orphan) begin
        $display("cycle %0d: result with no transaction pending: idx=%0d port=%0h cnt=%0d",
                 cycle_count, got.assigned_index, got.port_out, got.entry_count);
      end else begin
        $display("cycle %0d: expected idx=%0d port=%0h cnt=%0d new=%0b ok=%0b",
                 cycle_count, want.assigned_index, want.port_out, want.entry_count,
                 want.newly_added, want.in_range);
        $display("          actual   idx=%0d port=%0h cnt=%0d new=%0b ok=%0b",
                 got.assigned_index, got.port_out, got.entry_count,
                 got.newly_added, got.in_range);
      end
    end
  endtask

  // Inputs change on the falling edge; acceptance is seen at the rising edge.
  task automatic send_item(input func_e func, input logic [PortWidth-1:0] port,
                           input logic [PosWidth-1:0] position);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = func;
    port_i     = port;
    position_i = position;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results_q.push_back(predict_port_result(func, port, position));
  endtask

  task automatic wait_results_drained();
    while (expected_results_q.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed_result = {assigned_index_o, port_out_o, entry_count_o,
                         newly_added_o, in_range_o};
      if (expected_results_q.size() == 0) begin
        report_mismatch('0, observed_result, 1'b1);
      end else begin
        oldest_result = expected_results_q.pop_front();
        if (observed_result !== oldest_result) begin
          report_mismatch(oldest_result, observed_result, 1'b0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_index_directed();
    send_item(FUNC_INDEX, 16'h0000, '0);
    send_item(FUNC_INDEX, 16'hFFFF, '0);
    send_item(FUNC_INDEX, 16'h0000, '0);
    send_item(FUNC_INDEX, 16'h5555, 17'h1FFFF);
    send_item(FUNC_INDEX, 16'hAAAA, '0);
    send_item(FUNC_INDEX, 16'hFFFF, '0);
  endtask

  task automatic test_read_directed();
    send_item(FUNC_READ, 16'hFFFF, 17'd1);
    send_item(FUNC_READ, '0, 17'd4);
    send_item(FUNC_READ, '0, 17'd2);
    send_item(FUNC_READ, '0, 17'd0);
    send_item(FUNC_READ, '0, 17'd5);
    send_item(FUNC_READ, '0, 17'd65536);
    send_item(FUNC_READ, '0, 17'h1FFFF);
  endtask

  // After a clear the old positions read as out of range and keys restart at one.
  task automatic test_clear_and_nop_directed();
    send_item(FUNC_NOP, 16'hFFFF, 17'h1FFFF);
    send_item(FUNC_CLEAR, 16'h1234, 17'd1);
    send_item(FUNC_READ, '0, 17'd1);
    send_item(FUNC_INDEX, 16'hAAAA, '0);
    send_item(FUNC_INDEX, 16'h1234, '0);
    send_item(FUNC_READ, '0, 17'd1);
    send_item(FUNC_READ, '0, 17'd2);
    send_item(FUNC_NOP, '0, '0);
  endtask

  // Index traffic mostly draws keys from a small pool so that repeats are common and
  // reads mostly land on filled positions; the rest is noise and rare clears.
  task automatic test_random_traffic(input int n_items);
    int                   pick;
    logic [PortWidth-1:0] port;
    logic [PosWidth-1:0]  position;
    for (int k = 0; k < PoolSize; k++) begin
      port_pool[k] = PortWidth'($urandom_range(0, 65535));
    end
    port_pool[0] = '0;
    port_pool[1] = '1;
    for (int n = 0; n < n_items; n++) begin
      pick     = $urandom_range(0, 999);
      port     = PortWidth'($urandom_range(0, 65535));
      position = PosWidth'($urandom_range(0, 131071));
      if (pick >= 997 && clears_left > 0) begin
        clears_left--;
        send_item(FUNC_CLEAR, port, position);
      end else if (pick < 520 || pick >= 990) begin
        if ($urandom_range(0, 3) != 0) begin
          port = port_pool[$urandom_range(0, PoolSize - 1)];
        end
        send_item(FUNC_INDEX, port, position);
      end else if (pick < 940) begin
        if (distinct_count > 0 && $urandom_range(0, 4) != 0) begin
          position = PosWidth'($urandom_range(1, distinct_count));
        end else if ($urandom_range(0, 1) == 0) begin
          position = ($urandom_range(0, 1) == 0) ? '0 : PosWidth'(distinct_count + 1);
        end
        send_item(FUNC_READ, port, position);
      end else begin
        send_item(FUNC_NOP, port, position);
      end
    end
  endtask

  // The sender holds off until every result is back, then resumes.
  task automatic test_drain_pause();
    send_item(FUNC_INDEX, port_pool[2], '0);
    send_item(FUNC_INDEX, port_pool[3], '0);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_results_drained();
    send_item(FUNC_READ, '0, PosWidth'(distinct_count));
    send_item(FUNC_INDEX, port_pool[2], '0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_NOP;
    port_i         = '0;
    position_i     = '0;
    out_ready_i    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    distinct_count = 0;
    clears_left    = RandomClearBudget;
    send_idle_pct  = 6;
    recv_idle_pct  = 72;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_index_directed();
    test_read_directed();
    test_clear_and_nop_directed();
    test_random_traffic(500);
    test_drain_pause();

    send_idle_pct = 72;
    recv_idle_pct = 6;
    test_random_traffic(520);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(500);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_results_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
